// ===== rtl/core/ctps_pkg.sv =====
// ----------------------------------------------------------------------------
// Closest-timestamp pose selector package
// Shared types, register indexes, result codes and timestamp helper functions.
// ----------------------------------------------------------------------------
package ctps_pkg;

  typedef logic signed [63:0] stamp_t;
  typedef stamp_t rank_t [6];

  localparam stamp_t DIST_MAX = {1'b0, {63{1'b1}}};

  localparam logic [3:0] KIND_FIRST_HAND  = 4'd2;
  localparam logic [3:0] KIND_SECOND_HAND = 4'd3;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [31:0] MAX_AGE_RESET = 32'd100000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CAPTURE_EPOCH         = 3'd0,
    REG_CAPTURE_SPACE_EPOCH   = 3'd1,
    REG_CAPTURE_RECEIVER_TIME = 3'd2,
    REG_CAPTURE_OBSERVED_TIME = 3'd3,
    REG_CAPTURE_TARGET_TIME   = 3'd4,
    REG_REQUIRE_SENDER_TIMES  = 3'd5,
    REG_MAX_AGE               = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OUT_REPLACED   = 3'd0,
    OUT_KEPT_OLDER = 3'd1,
    OUT_BAD_KIND   = 3'd2,
    OUT_EPOCH_MISS = 3'd3,
    OUT_TOO_OLD    = 3'd4
  } outcome_t;

  // Negative stamps count as the largest possible distance.
  function automatic stamp_t dist_us(stamp_t a, stamp_t b);
    stamp_t d;
    d = a - b;
    if (a[63] || b[63]) begin
      return DIST_MAX;
    end else if (d[63]) begin
      return -d;
    end else begin
      return d;
    end
  endfunction

  // Lexicographic signed compare, true when a is strictly smaller than b.
  function automatic logic rank_less(rank_t a, rank_t b);
    logic lt;
    lt = 1'b0;
    for (int i = 5; i >= 0; i--) begin
      lt = (a[i] < b[i]) || ((a[i] == b[i]) && lt);
    end
    return lt;
  endfunction

endpackage

// ===== rtl/core/closest_timestamp_pose_selector.sv =====
// ----------------------------------------------------------------------------
// Closest-timestamp pose selector
// Keeps, for each of two hands, the pose sample that best matches the
// configured capture instant and reports one result per sample.
// A sample is registered in the input stage, then in the result register.
// Throughput: one sample per cycle unless out_stall; single compare stage.
// Reset: synchronous; clears both hand selections, the pipeline valids and
// the configuration registers (max_age returns to 100000).
// ----------------------------------------------------------------------------
module closest_timestamp_pose_selector
  import ctps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,

  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [3:0]              sample_kind,
  input  logic [31:0]             sample_epoch,
  input  logic [31:0]             sample_space_epoch,
  input  logic signed [63:0]      sample_observed_time,
  input  logic signed [63:0]      sample_target_time,
  input  logic signed [63:0]      arrival_time,
  input  logic [15:0]             sample_tag,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              outcome,
  output logic                    hand_index,
  output logic                    hand_has_selection,
  output logic [15:0]             selected_tag
);

  logic [31:0] capture_epoch;
  logic [31:0] capture_space_epoch;
  stamp_t      capture_receiver_time;
  stamp_t      capture_observed_time;
  stamp_t      capture_target_time;
  logic        require_sender_times;
  logic [31:0] max_age;

  logic        hand_selected [2];
  stamp_t      kept_target_time [2];
  stamp_t      kept_observed_time [2];
  stamp_t      kept_arrival_time [2];
  logic [15:0] kept_tag [2];

  logic        s1_valid;
  logic [3:0]  s1_kind;
  logic [31:0] s1_epoch;
  logic [31:0] s1_space_epoch;
  stamp_t      s1_observed;
  stamp_t      s1_target;
  stamp_t      s1_arrival;
  logic [15:0] s1_tag;

  outcome_t    outcome_reg;
  outcome_t    outcome_next;
  logic        hand_index_next;
  logic        has_sel_next;
  logic [15:0] tag_next;

  logic        advance;
  logic        in_xfer;
  logic        s1_hand;
  logic        kind_ok;
  logic        replace;
  stamp_t      lim;
  stamp_t      age_new;
  stamp_t      dobs_new;
  stamp_t      dtgt_new;
  rank_t       rank_new;
  rank_t       rank_kept;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign in_xfer   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_epoch         <= '0;
      capture_space_epoch   <= '0;
      capture_receiver_time <= '0;
      capture_observed_time <= '0;
      capture_target_time   <= '0;
      require_sender_times  <= 1'b0;
      max_age               <= MAX_AGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CAPTURE_EPOCH:         capture_epoch         <= cfg_data[31:0];
        REG_CAPTURE_SPACE_EPOCH:   capture_space_epoch   <= cfg_data[31:0];
        REG_CAPTURE_RECEIVER_TIME: capture_receiver_time <= cfg_data;
        REG_CAPTURE_OBSERVED_TIME: capture_observed_time <= cfg_data;
        REG_CAPTURE_TARGET_TIME:   capture_target_time   <= cfg_data;
        REG_REQUIRE_SENDER_TIMES:  require_sender_times  <= cfg_data[0];
        REG_MAX_AGE:               max_age               <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_xfer || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind        <= sample_kind;
      s1_epoch       <= sample_epoch;
      s1_space_epoch <= sample_space_epoch;
      s1_observed    <= sample_observed_time;
      s1_target      <= sample_target_time;
      s1_arrival     <= arrival_time;
      s1_tag         <= sample_tag;
    end
  end

  assign kind_ok  = (s1_kind == KIND_FIRST_HAND) || (s1_kind == KIND_SECOND_HAND);
  assign s1_hand  = s1_kind[0];
  assign lim      = {32'b0, max_age};
  assign age_new  = dist_us(s1_arrival, capture_receiver_time);
  assign dobs_new = dist_us(s1_observed, capture_observed_time);
  assign dtgt_new = dist_us(s1_target, capture_target_time);

  always_comb begin
    if (require_sender_times) begin
      rank_new[0]  = dtgt_new;
      rank_new[1]  = s1_target;
      rank_new[2]  = dobs_new;
      rank_new[3]  = s1_observed;
      rank_new[4]  = age_new;
      rank_new[5]  = s1_arrival;
      rank_kept[0] = dist_us(kept_target_time[s1_hand], capture_target_time);
      rank_kept[1] = kept_target_time[s1_hand];
      rank_kept[2] = dist_us(kept_observed_time[s1_hand], capture_observed_time);
      rank_kept[3] = kept_observed_time[s1_hand];
      rank_kept[4] = dist_us(kept_arrival_time[s1_hand], capture_receiver_time);
      rank_kept[5] = kept_arrival_time[s1_hand];
    end else begin
      rank_new[0]  = age_new;
      rank_new[1]  = s1_arrival;
      rank_kept[0] = dist_us(kept_arrival_time[s1_hand], capture_receiver_time);
      rank_kept[1] = kept_arrival_time[s1_hand];
      for (int i = 2; i < 6; i++) begin
        rank_new[i]  = '0;
        rank_kept[i] = '0;
      end
    end
  end

  always_comb begin
    replace         = 1'b0;
    outcome_next    = OUT_KEPT_OLDER;
    hand_index_next = s1_hand;
    has_sel_next    = hand_selected[s1_hand];
    tag_next        = hand_selected[s1_hand] ? kept_tag[s1_hand] : 16'd0;
    if (!kind_ok) begin
      outcome_next    = OUT_BAD_KIND;
      hand_index_next = 1'b0;
      has_sel_next    = 1'b0;
      tag_next        = 16'd0;
    end else if ((s1_epoch != capture_epoch) || (s1_space_epoch != capture_space_epoch)) begin
      outcome_next = OUT_EPOCH_MISS;
    end else if ((age_new > lim) ||
                 (require_sender_times && ((dobs_new > lim) || (dtgt_new > lim)))) begin
      outcome_next = OUT_TOO_OLD;
    end else if (!hand_selected[s1_hand] || rank_less(rank_new, rank_kept)) begin
      replace      = 1'b1;
      outcome_next = OUT_REPLACED;
      has_sel_next = 1'b1;
      tag_next     = s1_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hand_selected[0] <= 1'b0;
      hand_selected[1] <= 1'b0;
    end else if (s1_valid && advance && replace) begin
      hand_selected[s1_hand] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance && replace) begin
      kept_target_time[s1_hand]   <= s1_target;
      kept_observed_time[s1_hand] <= s1_observed;
      kept_arrival_time[s1_hand]  <= s1_arrival;
      kept_tag[s1_hand]           <= s1_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      outcome_reg        <= outcome_next;
      hand_index         <= hand_index_next;
      hand_has_selection <= has_sel_next;
      selected_tag       <= tag_next;
    end
  end

  assign outcome = outcome_reg;

  // A hand that holds a selection keeps it until reset.
  a_sel0_sticky: assert property (@(posedge clk) disable iff (rst)
    hand_selected[0] |=> hand_selected[0])
    else $error("hand 0 lost its selection");

  a_sel1_sticky: assert property (@(posedge clk) disable iff (rst)
    hand_selected[1] |=> hand_selected[1])
    else $error("hand 1 lost its selection");

  a_replaced_has_sel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome_reg == OUT_REPLACED)) |-> hand_has_selection)
    else $error("replaced result without a selection");

  a_bad_kind_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome_reg == OUT_BAD_KIND)) |->
      (!hand_has_selection && !hand_index && (selected_tag == 16'd0)))
    else $error("bad kind result carries nonzero fields");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_valid) |=> out_valid)
    else $error("input stage did not move into a free result register");

endmodule

// ===== tb/sv/tb_closest_timestamp_pose_selector.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Closest-timestamp pose selector testbench
// Feeds pose samples through directed cases and randomized register phases,
// with bursty sender pacing and patterned receiver stalls. A behavioral
// predictor tracks the kept sample of each hand, and every result transfer is
// compared field by field against the oldest predicted pick.
// ----------------------------------------------------------------------------
module tb_closest_timestamp_pose_selector;
  import ctps_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_ITEMS = 320;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam longint SPAN_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint STAMP_MIN = 64'sh8000_0000_0000_0000;
  localparam longint NEAR_TOP = 64'sh7FFF_FFFB_FFFF_FFFF;

  typedef struct {
    logic [3:0]  kind;
    logic [31:0] epoch;
    logic [31:0] region_epoch;
    longint      observed;
    longint      target;
    longint      arrival;
    logic [15:0] tag;
  } pose_sample_t;

  typedef struct {
    outcome_t    outcome;
    logic        hand;
    logic        has_sel;
    logic [15:0] tag;
  } pick_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [3:0]             sample_kind;
  logic [31:0]            sample_epoch;
  logic [31:0]            sample_space_epoch;
  logic signed [63:0]     sample_observed_time;
  logic signed [63:0]     sample_target_time;
  logic signed [63:0]     arrival_time;
  logic [15:0]            sample_tag;
  logic                   out_valid;
  logic                   out_stall;
  logic [2:0]             outcome;
  logic                   hand_index;
  logic                   hand_has_selection;
  logic [15:0]            selected_tag;

  closest_timestamp_pose_selector dut (.*);

  // Predictor copy of the registers and of the kept sample per hand.
  logic [31:0] cap_epoch;
  logic [31:0] cap_space_epoch;
  longint      cap_rx;
  longint      cap_obs;
  longint      cap_tgt;
  logic        need_sender;
  logic [31:0] max_age_us;
  logic        held [2];
  longint      held_tgt [2];
  longint      held_obs [2];
  longint      held_arr [2];
  logic [15:0] held_tag [2];

  pick_t  pick_q [$];
  int     failures;
  int     mismatches;
  int     quiet_cycles;
  logic   sender_bursty;
  int     burst_left;
  longint prev_obs;
  longint prev_tgt;
  longint prev_arr;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic longint span_us(longint a, longint b);
    if (a < 0 || b < 0) return SPAN_MAX;
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic longint rank_key(int i, longint tgt, longint obs, longint arr);
    if (!need_sender) begin
      case (i)
        0: return span_us(arr, cap_rx);
        1: return arr;
        default: return 0;
      endcase
    end
    case (i)
      0: return span_us(tgt, cap_tgt);
      1: return tgt;
      2: return span_us(obs, cap_obs);
      3: return obs;
      4: return span_us(arr, cap_rx);
      default: return arr;
    endcase
  endfunction

  function automatic logic ranks_before(longint tgt, longint obs, longint arr,
                                        longint k_tgt, longint k_obs, longint k_arr);
    longint a;
    longint b;
    for (int i = 0; i < 6; i++) begin
      a = rank_key(i, tgt, obs, arr);
      b = rank_key(i, k_tgt, k_obs, k_arr);
      if (a < b) return 1'b1;
      if (a > b) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic pick_t judge_sample(pose_sample_t s);
    pick_t  r;
    logic   h;
    longint lim;
    logic   better;
    lim = longint'({32'd0, max_age_us});
    r.outcome = OUT_BAD_KIND;
    r.hand = 1'b0;
    r.has_sel = 1'b0;
    r.tag = 16'd0;
    if (s.kind != KIND_FIRST_HAND && s.kind != KIND_SECOND_HAND) return r;
    h = (s.kind == KIND_SECOND_HAND);
    if (s.epoch != cap_epoch || s.region_epoch != cap_space_epoch) begin
      r.outcome = OUT_EPOCH_MISS;
    end else if (span_us(s.arrival, cap_rx) > lim ||
                 (need_sender && (span_us(s.observed, cap_obs) > lim ||
                                  span_us(s.target, cap_tgt) > lim))) begin
      r.outcome = OUT_TOO_OLD;
    end else begin
      better = !held[h] || ranks_before(s.target, s.observed, s.arrival,
                                        held_tgt[h], held_obs[h], held_arr[h]);
      if (better) begin
        held[h] = 1'b1;
        held_tgt[h] = s.target;
        held_obs[h] = s.observed;
        held_arr[h] = s.arrival;
        held_tag[h] = s.tag;
        r.outcome = OUT_REPLACED;
      end else begin
        r.outcome = OUT_KEPT_OLDER;
      end
    end
    r.hand = h;
    r.has_sel = held[h];
    r.tag = held[h] ? held_tag[h] : 16'd0;
    return r;
  endfunction

  task automatic reset_model();
    cap_epoch = '0;
    cap_space_epoch = '0;
    cap_rx = 0;
    cap_obs = 0;
    cap_tgt = 0;
    need_sender = 1'b0;
    max_age_us = MAX_AGE_RESET;
    for (int h = 0; h < 2; h++) begin
      held[h] = 1'b0;
      held_tgt[h] = 0;
      held_obs[h] = 0;
      held_arr[h] = 0;
      held_tag[h] = '0;
    end
    pick_q.delete();
  endtask

  task automatic apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_t'(idx))
      REG_CAPTURE_EPOCH:         cap_epoch = data[31:0];
      REG_CAPTURE_SPACE_EPOCH:   cap_space_epoch = data[31:0];
      REG_CAPTURE_RECEIVER_TIME: cap_rx = longint'(data);
      REG_CAPTURE_OBSERVED_TIME: cap_obs = longint'(data);
      REG_CAPTURE_TARGET_TIME:   cap_tgt = longint'(data);
      REG_REQUIRE_SENDER_TIMES:  need_sender = data[0];
      REG_MAX_AGE:               max_age_us = data[31:0];
      default: ;
    endcase
  endtask

  task automatic check_pick();
    pick_t want;
    if (pick_q.size() == 0) begin
      failures++;
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result outcome %0d hand %0d sel %0d tag %h",
                 $time, outcome, hand_index, hand_has_selection, selected_tag);
    end else begin
      want = pick_q.pop_front();
      if (outcome !== want.outcome || hand_index !== want.hand ||
          hand_has_selection !== want.has_sel || selected_tag !== want.tag) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected outcome %0d hand %0d sel %0d tag %h, got %0d %0d %0d %h",
                   $time, want.outcome, want.hand, want.has_sel, want.tag,
                   outcome, hand_index, hand_has_selection, selected_tag);
      end
    end
  endtask

  always @(posedge clk) begin
    pose_sample_t seen;
    if (rst) begin
      reset_model();
    end else begin
      if (out_valid && !out_stall) check_pick();
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        seen.kind = sample_kind;
        seen.epoch = sample_epoch;
        seen.region_epoch = sample_space_epoch;
        seen.observed = sample_observed_time;
        seen.target = sample_target_time;
        seen.arrival = arrival_time;
        seen.tag = sample_tag;
        pick_q.push_back(judge_sample(seen));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    stall_mode_t mode;
    int          k;
    out_stall = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      k = 0;
      repeat ($urandom_range(50, 300)) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:  out_stall = 1'b0;
          STALL_LIGHT: out_stall = ($urandom_range(0, 99) < 30);
          STALL_HEAVY: out_stall = ($urandom_range(0, 99) < 75);
          default:     out_stall = ((k % 40) < 25);
        endcase
        k++;
      end
    end
  end

  task automatic send_sample(pose_sample_t s);
    if (sender_bursty && burst_left == 0) begin
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    sample_kind = s.kind;
    sample_epoch = s.epoch;
    sample_space_epoch = s.region_epoch;
    sample_observed_time = s.observed;
    sample_target_time = s.target;
    arrival_time = s.arrival;
    sample_tag = s.tag;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pick_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_capture(longint rx, longint obs, longint tgt, logic sender,
                             logic [31:0] age);
    logic [63:0] v;
    write_reg(REG_CAPTURE_EPOCH, rand64());
    write_reg(REG_CAPTURE_SPACE_EPOCH, rand64());
    write_reg(REG_CAPTURE_RECEIVER_TIME, rx);
    write_reg(REG_CAPTURE_OBSERVED_TIME, obs);
    write_reg(REG_CAPTURE_TARGET_TIME, tgt);
    v = rand64();
    v[0] = sender;
    write_reg(REG_REQUIRE_SENDER_TIMES, v);
    v = rand64();
    v[31:0] = age;
    write_reg(REG_MAX_AGE, v);
  endtask

  function automatic pose_sample_t base_sample(logic [3:0] kind);
    pose_sample_t s;
    s.kind = kind;
    s.epoch = cap_epoch;
    s.region_epoch = cap_space_epoch;
    s.observed = cap_obs;
    s.target = cap_tgt;
    s.arrival = cap_rx;
    s.tag = 16'($urandom());
    return s;
  endfunction

  function automatic longint near(longint center, logic [63:0] spread);
    logic [63:0] r;
    r = rand64() % (2 * spread + 64'd1);
    return center + longint'(r) - longint'(spread);
  endfunction

  function automatic longint roll_time(longint v);
    logic [63:0] r;
    r = rand64();
    case ($urandom_range(0, 19))
      0: begin
        r[63] = 1'b1;
        return longint'(r);
      end
      1: return longint'(r);
      default: return v;
    endcase
  endfunction

  function automatic pose_sample_t draw_sample();
    pose_sample_t s;
    int          roll;
    logic [63:0] spread;
    roll = $urandom_range(0, 99);
    spread = {32'd0, max_age_us} + {34'd0, max_age_us[31:2]} + 64'd2;
    s = base_sample($urandom_range(0, 1) ? KIND_SECOND_HAND : KIND_FIRST_HAND);
    if (roll < 10) begin
      s.observed = prev_obs;
      s.target = prev_tgt;
      s.arrival = prev_arr;
    end else begin
      s.observed = roll_time(near(cap_obs, spread));
      s.target = roll_time(near(cap_tgt, spread));
      s.arrival = roll_time(near(cap_rx, spread));
    end
    if (roll >= 80 && roll < 88) begin
      s.kind = 4'($urandom());
    end else if (roll >= 88 && roll < 94) begin
      if ($urandom_range(0, 1)) s.epoch[$urandom_range(0, 31)] ^= 1'b1;
      else s.region_epoch = $urandom();
    end else if (roll >= 94) begin
      s.kind = 4'($urandom());
      s.epoch = $urandom();
      s.region_epoch = $urandom();
      s.observed = longint'(rand64());
      s.target = longint'(rand64());
      s.arrival = longint'(rand64());
    end
    prev_obs = s.observed;
    prev_tgt = s.target;
    prev_arr = s.arrival;
    return s;
  endfunction

  task automatic test_reset_defaults();
    pose_sample_t s;
    s = base_sample(KIND_SECOND_HAND);
    s.arrival = 100001;
    send_sample(s);
    s = base_sample(KIND_FIRST_HAND);
    s.arrival = 50000;
    send_sample(s);
    s = base_sample(KIND_SECOND_HAND);
    s.arrival = 100000;
    send_sample(s);
    s = base_sample(KIND_FIRST_HAND);
    s.arrival = -1;
    send_sample(s);
    s = base_sample(KIND_FIRST_HAND);
    s.arrival = 40000;
    send_sample(s);
    s.tag = ~s.tag;
    send_sample(s);
    wait_for_results();
  endtask

  task automatic test_bad_kinds();
    pose_sample_t s;
    logic [3:0]   kinds [4];
    kinds = '{4'h0, KIND_FIRST_HAND - 4'd1, KIND_SECOND_HAND + 4'd1, 4'hF};
    foreach (kinds[i]) begin
      s = base_sample(kinds[i]);
      s.arrival = longint'(rand64());
      s.tag = 16'hFFFF;
      send_sample(s);
    end
    wait_for_results();
  endtask

  task automatic test_epoch_checks();
    pose_sample_t s;
    write_reg(REG_CAPTURE_EPOCH, 64'hFFFF_FFFF);
    write_reg(REG_CAPTURE_SPACE_EPOCH, 64'h8000_0001);
    s = base_sample(KIND_FIRST_HAND);
    s.epoch[0] = 1'b0;
    s.arrival = SPAN_MAX;
    send_sample(s);
    s = base_sample(KIND_SECOND_HAND);
    s.region_epoch[31] = 1'b0;
    send_sample(s);
    s = base_sample(KIND_SECOND_HAND);
    s.arrival = 7;
    send_sample(s);
    wait_for_results();
  endtask

  task automatic test_sender_times();
    pose_sample_t s;
    write_reg(REG_CAPTURE_RECEIVER_TIME, 64'd1000000);
    write_reg(REG_CAPTURE_OBSERVED_TIME, 64'd2000000);
    write_reg(REG_CAPTURE_TARGET_TIME, 64'd3000000);
    write_reg(REG_REQUIRE_SENDER_TIMES, 64'd1);
    write_reg(REG_MAX_AGE, 64'd10);
    s = base_sample(KIND_FIRST_HAND);
    s.target = cap_tgt + 11;
    send_sample(s);
    s = base_sample(KIND_FIRST_HAND);
    s.observed = cap_obs - 11;
    send_sample(s);
    s = base_sample(KIND_FIRST_HAND);
    s.observed = STAMP_MIN;
    send_sample(s);
    s = base_sample(KIND_FIRST_HAND);
    s.target = cap_tgt + 3;
    send_sample(s);
    s = base_sample(KIND_FIRST_HAND);
    s.target = cap_tgt - 3;
    s.arrival = cap_rx + 10;
    send_sample(s);
    s.observed = cap_obs + 4;
    s.arrival = cap_rx;
    send_sample(s);
    wait_for_results();
  endtask

  task automatic test_register_extremes();
    pose_sample_t s;
    write_reg(REG_CAPTURE_RECEIVER_TIME, SPAN_MAX);
    write_reg(REG_MAX_AGE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_REQUIRE_SENDER_TIMES, 64'hFFFF_FFFF_FFFF_FFFE);
    s = base_sample(KIND_SECOND_HAND);
    send_sample(s);
    s.arrival = SPAN_MAX - 64'sh0000_0000_FFFF_FFFF;
    send_sample(s);
    wait_for_results();
    write_reg(REG_CAPTURE_RECEIVER_TIME, STAMP_MIN);
    s = base_sample(KIND_FIRST_HAND);
    s.arrival = 0;
    send_sample(s);
    wait_for_results();
    write_reg(REG_CAPTURE_RECEIVER_TIME, 64'd12345);
    write_reg(REG_MAX_AGE, 64'hDEAD_BEEF_0000_0000);
    s = base_sample(KIND_FIRST_HAND);
    send_sample(s);
    s.arrival = 12346;
    send_sample(s);
    wait_for_results();
    write_reg(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
    s = base_sample(KIND_FIRST_HAND);
    send_sample(s);
    wait_for_results();
  endtask

  task automatic test_random_phases();
    longint base;
    sender_bursty = 1'b1;
    for (int phase = 0; phase < 6; phase++) begin
      base = longint'({24'd0, 8'($urandom()), 32'($urandom())});
      case (phase)
        0: set_capture(base, base + 500, base - 900, 1'b0, 32'd5000);
        1: set_capture(base, base, base, 1'b0, 32'd4);
        2: set_capture(base, base - 3, base + 40, 1'b1, 32'd6);
        3: set_capture(base, base + 1, base + 2, 1'b1, 32'd0);
        4: set_capture(NEAR_TOP, NEAR_TOP - 1000, NEAR_TOP - 77, 1'b1, 32'hFFFF_FFFF);
        default: set_capture(0, 0, 0, 1'b0, MAX_AGE_RESET);
      endcase
      prev_obs = cap_obs;
      prev_tgt = cap_tgt;
      prev_arr = cap_rx;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(draw_sample());
        if ($urandom_range(0, 149) == 0) wait_for_results();
      end
      wait_for_results();
    end
    sender_bursty = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    sample_kind = '0;
    sample_epoch = '0;
    sample_space_epoch = '0;
    sample_observed_time = '0;
    sample_target_time = '0;
    arrival_time = '0;
    sample_tag = '0;
    failures = 0;
    mismatches = 0;
    sender_bursty = 1'b0;
    burst_left = 0;
    prev_obs = 0;
    prev_tgt = 0;
    prev_arr = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_bad_kinds();
    test_epoch_checks();
    test_sender_times();
    test_register_extremes();
    test_random_phases();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pick_q.size() != 0) begin
      failures++;
      $display("%0d predicted results never arrived", pick_q.size());
    end
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
